@@ rtl/random_removal_queue_assert.svh @@
// Assertion macros for the random removal queue checker.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef RANDOM_REMOVAL_QUEUE_ASSERT_SVH
`define RANDOM_REMOVAL_QUEUE_ASSERT_SVH

// Same-cycle implication
`define RRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rrq assertion failed");

// Next-cycle implication
`define RRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rrq assertion failed");

`endif

@@ rtl/rrq_pkg.sv @@
// Shared constants for the random removal queue.
// No dependencies; imported by the queue, its remainder unit and its checker.
package rrq_pkg;

    // default sizing
    localparam int DEPTH_DEF      = 256;
    localparam int ITEM_WIDTH_DEF = 32;

    // fixed field widths
    localparam int ITEM_OUT_W = 32;
    localparam int RND_W      = 16;
    localparam int CAP_W      = 9;
    localparam int STATUS_W   = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // opcodes
    localparam logic OP_PUT = 1'b0;
    localparam logic OP_GET = 1'b1;

    // remainder unit: bits retired per cycle and iteration count
    localparam int DIV_STEP   = 4;
    localparam int DIV_ITERS  = RND_W / DIV_STEP;
    localparam int DIV_ITER_W = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;

endpackage

@@ rtl/rrq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rrq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held while not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rrq_divmod.sv @@
// Iterative remainder unit: dividend modulo divisor, DIV_STEP bits per cycle.
// Depends on rrq_pkg.
module rrq_divmod
    import rrq_pkg::*;
#(
    parameter int DIV_W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RND_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [DIV_W-1:0] o_rem
);

    logic                  r_busy, n_busy;
    logic [DIV_ITER_W-1:0] r_iter, n_iter;
    logic [RND_W-1:0]      r_num, n_num;
    logic [DIV_W-1:0]      r_rem, n_rem;
    logic [DIV_W-1:0]      r_div, n_div;
    logic [DIV_W-1:0]      w_rem;
    logic [RND_W-1:0]      w_num;

    // restoring remainder steps for this cycle
    always_comb begin
        logic [DIV_W:0] t;
        w_rem = r_rem;
        w_num = r_num;
        for (int k = 0; k < DIV_STEP; k++) begin
            t = {w_rem, w_num[RND_W-1]};
            if (t >= {1'b0, r_div}) begin
                t = t - {1'b0, r_div};
            end
            w_rem = t[DIV_W-1:0];
            w_num = {w_num[RND_W-2:0], 1'b0};
        end
    end

    // sequencing
    always_comb begin
        n_busy = r_busy;
        n_iter = r_iter;
        n_num  = r_num;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_iter = '0;
            n_num  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_num  = w_num;
            n_rem  = w_rem;
            n_iter = r_iter + 1'b1;
            if (r_iter == DIV_ITER_W'(DIV_ITERS - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_iter <= '0;
        end else begin
            r_busy <= n_busy;
            r_iter <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

@@ rtl/random_removal_queue.sv @@
// Random removal queue: a put appends, a get removes a randomly chosen entry.
// A put passes through the states EXEC and OUT before its result is registered on m_axis;
// a get also passes through LAST, DIV and READ, waiting in DIV for the 4-bit-per-cycle
// remainder unit, and makes two reads and one write-back on the entry RAM's single read port.
// Words are accepted only in IDLE, so a new word waits until the last result is in the output register.
// Reset: count 0, capacity 256; the entry RAM is not cleared.
module random_removal_queue
    import rrq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int ITEM_WIDTH = ITEM_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration: capacity
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    // input words
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [47:0]      s_axis_tdata,   // item_value[31:0], random_word[47:32]
    input  logic [0:0]       s_axis_tuser,   // opcode[0]
    // result words
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // item_out[31:0]
    output logic [2:0]       m_axis_tuser    // status[1:0], now_empty[2]
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CAP_W-1:0]      r_capacity;
    logic                  r_op, n_op;
    logic [ITEM_WIDTH-1:0] r_val, n_val;
    logic [RND_W-1:0]      r_rnd, n_rnd;
    logic [ITEM_WIDTH-1:0] r_move, n_move;
    logic [ITEM_OUT_W-1:0] r_res_item, n_res_item;
    logic [STATUS_W-1:0]   r_res_status, n_res_status;
    logic                  r_m_valid, n_m_valid;
    logic [ITEM_OUT_W-1:0] r_m_item, n_m_item;
    logic [STATUS_W-1:0]   r_m_status, n_m_status;
    logic                  r_m_empty, n_m_empty;

    logic                  w_accept;
    logic [63:0]           w_in64;
    logic [63:0]           w_rd64;
    logic [CW-1:0]         w_last;
    logic                  w_full;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [ITEM_WIDTH-1:0] ram_wdata, ram_rdata;

    logic                  div_start, div_busy;
    logic [CW-1:0]         div_rem;

    rrq_ram #(
        .WIDTH (ITEM_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rrq_divmod #(
        .DIV_W (CW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_count),
        .o_busy     (div_busy),
        .o_rem      (div_rem)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // width adaption of stored values
    assign w_in64 = {32'b0, s_axis_tdata[31:0]};
    assign w_rd64 = 64'(ram_rdata);
    assign w_last = r_count - 1'b1;
    assign w_full = (CMPW'(r_count) >= CMPW'(r_capacity)) || (r_count >= CW'(DEPTH));

    // control sequence
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_op         = r_op;
        n_val        = r_val;
        n_rnd        = r_rnd;
        n_move       = r_move;
        n_res_item   = r_res_item;
        n_res_status = r_res_status;
        n_m_valid    = r_m_valid;
        n_m_item     = r_m_item;
        n_m_status   = r_m_status;
        n_m_empty    = r_m_empty;
        ram_we       = 1'b0;
        ram_waddr    = r_count[AW-1:0];
        ram_wdata    = r_val;
        ram_re       = 1'b0;
        ram_raddr    = w_last[AW-1:0];
        div_start    = 1'b0;

        // output register drains independently
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op    = s_axis_tuser[0];
                    n_val   = w_in64[ITEM_WIDTH-1:0];
                    n_rnd   = s_axis_tdata[47:32];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_item   = '0;
                n_res_status = ST_OK;
                if (r_op == OP_PUT) begin
                    if (w_full) begin
                        n_res_status = ST_FULL;
                    end else begin
                        ram_we  = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                    n_state = S_OUT;
                end else if (r_count == '0) begin
                    n_res_status = ST_EMPTY;
                    n_state      = S_OUT;
                end else begin
                    // fetch the last live entry while the index is worked out
                    div_start = 1'b1;
                    ram_re    = 1'b1;
                    n_state   = S_LAST;
                end
            end
            S_LAST: begin
                n_move  = ram_rdata;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!div_busy) begin
                    ram_re    = 1'b1;
                    ram_raddr = div_rem[AW-1:0];
                    n_state   = S_READ;
                end
            end
            S_READ: begin
                // return chosen entry, fill its slot with the last one
                n_res_item = w_rd64[ITEM_OUT_W-1:0];
                ram_we     = 1'b1;
                ram_waddr  = div_rem[AW-1:0];
                ram_wdata  = r_move;
                n_count    = w_last;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid  = 1'b1;
                    n_m_item   = r_res_item;
                    n_m_status = r_res_status;
                    n_m_empty  = (r_count == '0);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_capacity <= CAP_RESET;
            r_m_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_val        <= n_val;
        r_rnd        <= n_rnd;
        r_move       <= n_move;
        r_res_item   <= n_res_item;
        r_res_status <= n_res_status;
        r_m_item     <= n_m_item;
        r_m_status   <= n_m_status;
        r_m_empty    <= n_m_empty;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_item;
    assign m_axis_tuser  = {r_m_empty, r_m_status};

endmodule

@@ rtl/rrq_checker.sv @@
// Port-level checker for the random removal queue, bound to the top level.
// Depends on rrq_pkg and random_removal_queue_assert.svh.
`include "random_removal_queue_assert.svh"

module rrq_checker
    import rrq_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cfg_we,
    input logic [CAP_W-1:0] i_cfg_wdata,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [47:0]      s_axis_tdata,
    input logic [0:0]       s_axis_tuser,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [31:0]      m_axis_tdata,
    input logic [2:0]       m_axis_tuser
);

    // a stalled result word holds
    `RRQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // one word in flight: input closes right after an accept
    `RRQ_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // refused operations return zero data
    `RRQ_ASSERT_IMP(a_refused_zero, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser[1:0] != ST_OK), m_axis_tdata == 32'd0)

    // a refused get leaves the queue empty
    `RRQ_ASSERT_IMP(a_empty_flag, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser[1:0] == ST_EMPTY), m_axis_tuser[2])

endmodule

bind random_removal_queue rrq_checker u_rrq_checker (.*);

@@ dv/tb_random_removal_queue.sv @@
// Self-checking testbench for random_removal_queue: directed and random put/get traffic
// with random stalls on both streams, checked against a behavioral model of the queue.
// Depends on rrq_pkg and the random_removal_queue RTL only.
module tb_random_removal_queue;
    import rrq_pkg::*;

    localparam int unsigned QDEPTH = DEPTH_DEF;

    typedef struct packed {
        logic        op;
        logic [31:0] value;
        logic [15:0] rnd;
    } queue_cmd_t;

    typedef struct packed {
        logic [31:0]         item;
        logic [STATUS_W-1:0] status;
        logic                empty;
    } queue_rsp_t;

    // DUT signals; all that the bench drives are known from time zero
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [CAP_W-1:0] i_cfg_wdata   = '0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [47:0]      s_axis_tdata  = '0;   // item_value[31:0], random_word[47:32]
    logic [0:0]       s_axis_tuser  = '0;   // opcode[0]
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [31:0]      m_axis_tdata;         // item_out[31:0]
    logic [2:0]       m_axis_tuser;         // status[1:0], now_empty[2]

    // model state
    logic [31:0]      queue_store [QDEPTH];
    int unsigned      queue_count = 0;
    logic [CAP_W-1:0] queue_cap   = CAP_RESET;

    queue_cmd_t pending_words [$];
    queue_rsp_t expected_results [$];

    // driver / receiver bookkeeping
    queue_cmd_t  tx_word;
    queue_rsp_t  want;
    bit          sending       = 1'b0;
    bit          word_taken    = 1'b0;
    int unsigned gap_left      = 0;
    int unsigned tx_calm_left  = 0;
    int unsigned words_in      = 0;
    int unsigned hold_left     = 0;
    bit          hold_done     = 1'b0;
    int unsigned rx_stall_left = 0;
    int unsigned rx_calm_left  = 0;
    bit          rx_ready      = 1'b0;
    int unsigned errors        = 0;

    random_removal_queue uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // One queue operation: updates the model and returns the result word it yields
    function automatic queue_rsp_t predict_queue_op(queue_cmd_t w);
        queue_rsp_t  r;
        int unsigned limit;
        int unsigned pick;
        r        = '0;
        r.status = ST_OK;
        limit    = (queue_cap > QDEPTH) ? QDEPTH : queue_cap;
        if (w.op == OP_PUT) begin
            if (queue_count >= limit) begin
                r.status = ST_FULL;
            end else begin
                queue_store[queue_count] = w.value;
                queue_count++;
            end
        end else if (queue_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            // swap the last live entry into the hole
            pick              = w.rnd % queue_count;
            r.item            = queue_store[pick];
            queue_store[pick] = queue_store[queue_count - 1];
            queue_count--;
        end
        r.empty = (queue_count == 0);
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_cmd(input logic op, input logic [31:0] value, input logic [15:0] rnd);
        queue_cmd_t w;
        w.op    = op;
        w.value = value;
        w.rnd   = rnd;
        pending_words.push_back(w);
    endtask

    // let the sender run dry and every result come back
    task automatic wait_idle();
        while (pending_words.size() != 0 || sending || expected_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= cap;
        queue_cap    = cap;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // random traffic under one capacity; put_pct steers the fill level
    task automatic random_phase(input logic [CAP_W-1:0] cap, input int n, input int put_pct);
        logic        op;
        logic [31:0] value;
        logic [15:0] rnd;
        int unsigned r;
        set_capacity(cap);
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(0, 99) < put_pct) ? OP_PUT : OP_GET;
            r  = $urandom_range(0, 15);
            case (r)
                0: value = 32'h8000_0000;
                1: value = 32'h7fff_ffff;
                2: value = 32'h0000_0000;
                3: value = 32'hffff_ffff;
                default: value = $urandom;
            endcase
            r = $urandom_range(0, 9);
            case (r)
                0: rnd = 16'h0000;
                1: rnd = 16'hffff;
                default: rnd = $urandom_range(0, 65535);
            endcase
            push_cmd(op, value, rnd);
        end
    endtask

    // Sender: launches the next word at the falling edge
    always @(negedge i_clk) begin
        if (word_taken) begin
            word_taken = 1'b0;
            sending    = 1'b0;
            if (tx_calm_left > 0) begin
                tx_calm_left--;
            end else begin
                gap_left = pick_gap();
                if ($urandom_range(0, 40) == 0)
                    tx_calm_left = $urandom_range(20, 80);
            end
        end
        if (!sending && i_rst_n) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_words.size() > 0) begin
                tx_word = pending_words.pop_front();
                s_axis_tdata <= {tx_word.rnd, tx_word.value};
                s_axis_tuser <= tx_word.op;
                sending = 1'b1;
            end
        end
        s_axis_tvalid <= sending;
    end

    // Input side: every accepted word yields one expected result
    always @(posedge i_clk) begin
        queue_cmd_t w;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            w.op    = s_axis_tuser[0];
            w.value = s_axis_tdata[31:0];
            w.rnd   = s_axis_tdata[47:32];
            expected_results.push_back(predict_queue_op(w));
            word_taken = 1'b1;
            words_in++;
        end
    end

    // Receiver: random back-pressure plus one long hold-off to fill the block
    always @(negedge i_clk) begin
        if (!hold_done && words_in >= 150) begin
            hold_left = 300;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            rx_ready = 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            rx_ready = 1'b0;
        end else begin
            rx_ready = 1'b1;
            if (rx_calm_left > 0)
                rx_calm_left--;
            else if ($urandom_range(0, 3) == 0)
                rx_stall_left = pick_gap();
            else if ($urandom_range(0, 60) == 0)
                rx_calm_left = $urandom_range(30, 100);
        end
        m_axis_tready <= rx_ready;
    end

    // Output side: compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word: tdata %h tuser %h", m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata !== want.item) begin
                    $error("item_out: expected %h, got %h", want.item, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser[1:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser[1:0]);
                    errors++;
                end
                if (m_axis_tuser[2] !== want.empty) begin
                    $error("now_empty: expected %0b, got %0b", want.empty, m_axis_tuser[2]);
                    errors++;
                end
            end
        end
    end

    // Stimulus sequence
    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset capacity: get on empty, value extremes, get index extremes, drain to empty
        push_cmd(OP_GET, 32'h0000_0000, 16'h0000);
        push_cmd(OP_PUT, 32'h7fff_ffff, 16'hffff);
        push_cmd(OP_PUT, 32'h8000_0000, 16'h0000);
        push_cmd(OP_PUT, 32'h0000_0000, 16'haaaa);
        push_cmd(OP_PUT, 32'hffff_ffff, 16'h5555);
        push_cmd(OP_PUT, 32'haaaa_5555, 16'h0001);
        push_cmd(OP_GET, 32'hffff_ffff, 16'hffff);
        push_cmd(OP_GET, 32'h0000_0000, 16'h0000);
        push_cmd(OP_GET, 32'h1234_5678, 16'haaaa);
        push_cmd(OP_GET, 32'h0000_0000, 16'h5555);
        push_cmd(OP_GET, 32'h0000_0000, 16'h0001);
        push_cmd(OP_GET, 32'h0000_0000, 16'hffff);

        // small capacity: full refusal and refill after a get
        set_capacity(9'd2);
        push_cmd(OP_PUT, 32'h0000_0011, 16'h0000);
        push_cmd(OP_PUT, 32'h0000_0022, 16'h0000);
        push_cmd(OP_PUT, 32'h0000_0033, 16'h0000);
        push_cmd(OP_GET, 32'h0000_0000, 16'h0003);
        push_cmd(OP_PUT, 32'h5555_aaaa, 16'h0000);
        push_cmd(OP_PUT, 32'h0000_0044, 16'h0000);
        push_cmd(OP_GET, 32'h0000_0000, 16'h0000);
        push_cmd(OP_GET, 32'h0000_0000, 16'h0007);
        push_cmd(OP_GET, 32'h0000_0000, 16'h0000);

        // fill to depth, then shrink capacity below the fill level and drain
        random_phase(9'd256, 420, 85);
        random_phase(9'd5,   120, 40);
        random_phase(9'd0,    80, 50);
        random_phase(9'd511, 200, 80);
        random_phase(9'd256, 200, 30);
        random_phase(9'd1,    80, 50);
        random_phase(9'd3,    80, 50);
        random_phase($urandom_range(0, 511), 60, 55);
        random_phase($urandom_range(0, 511), 60, 55);

        wait_idle();
        repeat (20) @(negedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("[random_removal_queue] OK");
        end else begin
            $display("[random_removal_queue] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("[random_removal_queue] ERROR");
        $finish;
    end

endmodule
